// File: rtl/core/xie_pkg.sv
`default_nettype none
package xie_pkg;

    localparam int MAX_BYTES   = 12;
    localparam int CNT_BITS    = 4;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int QUEUE_DEPTH = 2;

    // op codes
    localparam logic [5:0] OP_MOV_IMM64 = 6'd0;
    localparam logic [5:0] OP_MOV_RR    = 6'd1;
    localparam logic [5:0] OP_MOV_LD    = 6'd2;
    localparam logic [5:0] OP_MOV_ST    = 6'd3;
    localparam logic [5:0] OP_MOV_MIMM  = 6'd4;
    localparam logic [5:0] OP_LEA       = 6'd5;
    localparam logic [5:0] OP_ADD_RR    = 6'd6;
    localparam logic [5:0] OP_ADD_IMM   = 6'd7;
    localparam logic [5:0] OP_SUB_RR    = 6'd8;
    localparam logic [5:0] OP_SUB_IMM   = 6'd9;
    localparam logic [5:0] OP_IMUL      = 6'd10;
    localparam logic [5:0] OP_IDIV      = 6'd11;
    localparam logic [5:0] OP_CQO       = 6'd12;
    localparam logic [5:0] OP_AND       = 6'd13;
    localparam logic [5:0] OP_OR        = 6'd14;
    localparam logic [5:0] OP_XOR       = 6'd15;
    localparam logic [5:0] OP_SHL       = 6'd16;
    localparam logic [5:0] OP_SHR       = 6'd17;
    localparam logic [5:0] OP_SAR       = 6'd18;
    localparam logic [5:0] OP_CMP_RR    = 6'd19;
    localparam logic [5:0] OP_CMP_IMM   = 6'd20;
    localparam logic [5:0] OP_CMP_MB    = 6'd21;
    localparam logic [5:0] OP_TEST      = 6'd22;
    localparam logic [5:0] OP_PUSH      = 6'd23;
    localparam logic [5:0] OP_POP       = 6'd24;
    localparam logic [5:0] OP_JMP       = 6'd25;
    localparam logic [5:0] OP_JCC       = 6'd26;
    localparam logic [5:0] OP_CALL      = 6'd27;
    localparam logic [5:0] OP_RET       = 6'd28;
    localparam logic [5:0] OP_VZEROALL  = 6'd29;
    localparam logic [5:0] OP_VPBCASTQ  = 6'd30;
    localparam logic [5:0] OP_VMOVDQU_LD = 6'd31;
    localparam logic [5:0] OP_VMOVDQU_ST = 6'd32;
    localparam logic [5:0] OP_VPMULUDQ  = 6'd33;
    localparam logic [5:0] OP_VPADDQ_RR = 6'd34;
    localparam logic [5:0] OP_VPADDQ_M  = 6'd35;
    localparam logic [5:0] OP_VBCASTSD  = 6'd36;
    localparam logic [5:0] OP_VMOVUPD_LD = 6'd37;
    localparam logic [5:0] OP_VMOVUPD_ST = 6'd38;
    localparam logic [5:0] OP_VMULPD    = 6'd39;
    localparam logic [5:0] OP_VADDPD    = 6'd40;
    localparam logic [5:0] OP_VFMADD_RR = 6'd41;
    localparam logic [5:0] OP_VFMADD_M  = 6'd42;
    localparam logic [5:0] OP_VXORPD    = 6'd43;

    // one encoded instruction travelling from front to back
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_BITS-1:0]       count;
    } word_t;

endpackage
`default_nettype wire

// File: rtl/core/x86_64_instruction_encoder.sv
// Channel   Handshake      Payload
// input     push / full    op, reg_a..c, base_reg, index_reg, scale_code,
//                          displacement, immediate, cond_code, jump_target
// result    empty / pop    out_byte, last
//
// The front encodes a request in the cycle it is accepted and passes a word
// of up to twelve bytes through a two-entry queue to the back.
// The back sends one byte per cycle while pop is high; that serialiser sets
// the rate. Requests with no encoding are taken and dropped. Reset clears
// the offset, the queue and the serialiser. full rises only when the queue
// holds two words.
`default_nettype none
module x86_64_instruction_encoder #(
    parameter int OFFSET_BITS = xie_pkg::OFFSET_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [5:0]  op,
    input  wire logic [3:0]  reg_a,
    input  wire logic [3:0]  reg_b,
    input  wire logic [3:0]  reg_c,
    input  wire logic [3:0]  base_reg,
    input  wire logic [3:0]  index_reg,
    input  wire logic [1:0]  scale_code,
    input  wire logic signed [31:0] displacement,
    input  wire logic signed [63:0] immediate,
    input  wire logic [3:0]  cond_code,
    input  wire logic [31:0] jump_target,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             last
);
    import xie_pkg::*;

    word_t f_word, b_word;
    logic  q_full, q_push, q_valid, q_rd;

    xie_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .reg_a(reg_a), .reg_b(reg_b), .reg_c(reg_c), .base_reg(base_reg),
        .index_reg(index_reg), .scale_code(scale_code),
        .displacement(displacement), .immediate(immediate),
        .cond_code(cond_code), .jump_target(jump_target),
        .q_full(q_full), .q_push(q_push), .q_word(f_word)
    );

    xie_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(q_push), .wr_word(f_word),
        .q_full(q_full), .rd(q_rd), .q_valid(q_valid), .rd_word(b_word)
    );

    xie_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(b_word),
        .q_rd(q_rd), .empty(empty), .pop(pop), .out_byte(out_byte),
        .last(last)
    );

endmodule
`default_nettype wire

// File: rtl/core/xie_front.sv
`default_nettype none
module xie_front #(
    parameter int OFFSET_BITS = xie_pkg::OFFSET_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [5:0]  op,
    input  wire logic [3:0]  reg_a,
    input  wire logic [3:0]  reg_b,
    input  wire logic [3:0]  reg_c,
    input  wire logic [3:0]  base_reg,
    input  wire logic [3:0]  index_reg,
    input  wire logic [1:0]  scale_code,
    input  wire logic signed [31:0] displacement,
    input  wire logic signed [63:0] immediate,
    input  wire logic [3:0]  cond_code,
    input  wire logic [31:0] jump_target,
    input  wire logic        q_full,
    output logic             q_push,
    output xie_pkg::word_t   q_word
);
    import xie_pkg::*;

    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [MAX_BYTES-1:0][7:0] bb;
    logic [CNT_BITS-1:0] n;
    logic       rex_en, vex_en, modrm_en, mem_en, sib_en, rel_en;
    logic [7:0] rex_val, v1, v2, mr_val, ob0, ob1, ob2;
    logic [1:0] opn;
    logic [3:0] imm_n;
    logic [2:0] mem_reg;
    logic [1:0] mode;
    logic [OFFSET_BITS-1:0] pos;
    logic [31:0] rel;

    assign full = q_full;

    // choose disp8 / disp32 / none
    always_comb
    begin
        if (displacement == 32'sd0 && base_reg[2:0] != 3'd5)
            mode = 2'd0;
        else if (displacement[31:7] == {25{displacement[7]}})
            mode = 2'd1;
        else
            mode = 2'd2;
    end

    // rel32 from the position after the opcode bytes and the rel32 field
    always_comb
    begin
        pos = offset_reg + ((op == OP_JCC) ? OFFSET_BITS'(2) : OFFSET_BITS'(1));
        rel = jump_target - 32'(pos) - 32'd4;
    end

    // classify the op into prefix, opcode, operand and immediate sections
    always_comb
    begin
        rex_en = 1'b0; vex_en = 1'b0; modrm_en = 1'b0; mem_en = 1'b0;
        sib_en = 1'b0; rel_en = 1'b0;
        rex_val = 8'h48; v1 = 8'h00; v2 = 8'h00; mr_val = 8'h00;
        ob0 = 8'h00; ob1 = 8'h00; ob2 = 8'h00; opn = 2'd0; imm_n = 4'd0;
        mem_reg = reg_a[2:0];
        unique case (op)
            OP_MOV_IMM64:
            begin
                rex_en = 1'b1; rex_val = 8'h48 | {7'd0, reg_a[3]};
                opn = 2'd1; ob0 = 8'hB8 + {5'd0, reg_a[2:0]}; imm_n = 4'd8;
            end
            OP_MOV_RR, OP_ADD_RR, OP_SUB_RR, OP_AND, OP_OR, OP_XOR, OP_CMP_RR,
            OP_TEST:
            begin
                rex_en = 1'b1;
                rex_val = {5'b01001, reg_b[3], 1'b0, reg_a[3]};
                opn = 2'd1;
                priority case (op)
                    OP_MOV_RR: ob0 = 8'h89;
                    OP_ADD_RR: ob0 = 8'h01;
                    OP_SUB_RR: ob0 = 8'h29;
                    OP_AND:    ob0 = 8'h21;
                    OP_OR:     ob0 = 8'h09;
                    OP_XOR:    ob0 = 8'h31;
                    OP_CMP_RR: ob0 = 8'h39;
                    default:   ob0 = 8'h85;
                endcase
                modrm_en = 1'b1; mr_val = {2'b11, reg_b[2:0], reg_a[2:0]};
            end
            OP_MOV_LD, OP_MOV_ST, OP_LEA:
            begin
                rex_en = 1'b1;
                rex_val = {5'b01001, reg_a[3], 1'b0, base_reg[3]};
                opn = 2'd1;
                ob0 = (op == OP_MOV_LD) ? 8'h8B : (op == OP_MOV_ST) ? 8'h89 : 8'h8D;
                mem_en = 1'b1;
            end
            OP_MOV_MIMM:
            begin
                rex_en = 1'b1; rex_val = 8'h48 | {7'd0, base_reg[3]};
                opn = 2'd1; ob0 = 8'hC7; mem_en = 1'b1; mem_reg = 3'd0;
                imm_n = 4'd4;
            end
            OP_ADD_IMM, OP_SUB_IMM, OP_CMP_IMM:
            begin
                rex_en = 1'b1; rex_val = 8'h48 | {7'd0, reg_a[3]};
                opn = 2'd1; ob0 = 8'h81; modrm_en = 1'b1;
                mr_val = {2'b11, (op == OP_ADD_IMM) ? 3'd0 :
                          (op == OP_SUB_IMM) ? 3'd5 : 3'd7, reg_a[2:0]};
                imm_n = 4'd4;
            end
            OP_IMUL:
            begin
                rex_en = 1'b1;
                rex_val = {5'b01001, reg_a[3], 1'b0, reg_b[3]};
                opn = 2'd2; ob0 = 8'h0F; ob1 = 8'hAF;
                modrm_en = 1'b1; mr_val = {2'b11, reg_a[2:0], reg_b[2:0]};
            end
            OP_IDIV:
            begin
                rex_en = 1'b1; rex_val = 8'h48 | {7'd0, reg_a[3]};
                opn = 2'd1; ob0 = 8'hF7;
                modrm_en = 1'b1; mr_val = {2'b11, 3'd7, reg_a[2:0]};
            end
            OP_CQO:
            begin
                opn = 2'd2; ob0 = 8'h48; ob1 = 8'h99;
            end
            OP_SHL, OP_SHR, OP_SAR:
            begin
                rex_en = 1'b1; rex_val = 8'h48 | {7'd0, reg_a[3]};
                opn = 2'd1; ob0 = 8'hC1; modrm_en = 1'b1;
                mr_val = {2'b11, (op == OP_SHL) ? 3'd4 :
                          (op == OP_SHR) ? 3'd5 : 3'd7, reg_a[2:0]};
                imm_n = 4'd1;
            end
            OP_CMP_MB:
            begin
                rex_en = base_reg[3]; rex_val = 8'h41;
                opn = 2'd1; ob0 = 8'h80; mem_en = 1'b1; mem_reg = 3'd7;
                imm_n = 4'd1;
            end
            OP_PUSH, OP_POP:
            begin
                rex_en = reg_a[3]; rex_val = 8'h41; opn = 2'd1;
                ob0 = ((op == OP_PUSH) ? 8'h50 : 8'h58) + {5'd0, reg_a[2:0]};
            end
            OP_JMP:
            begin
                opn = 2'd1; ob0 = 8'hE9; rel_en = 1'b1;
            end
            OP_JCC:
            begin
                opn = 2'd2; ob0 = 8'h0F; ob1 = 8'h80 + {4'd0, cond_code};
                rel_en = 1'b1;
            end
            OP_CALL:
            begin
                rex_en = reg_a[3]; rex_val = 8'h41; opn = 2'd1; ob0 = 8'hFF;
                modrm_en = 1'b1; mr_val = {2'b11, 3'd2, reg_a[2:0]};
            end
            OP_RET:
            begin
                opn = 2'd1; ob0 = 8'hC3;
            end
            OP_VZEROALL:
            begin
                opn = 2'd3; ob0 = 8'hC5; ob1 = 8'hFC; ob2 = 8'h77;
            end
            OP_VPBCASTQ, OP_VBCASTSD:
            begin
                vex_en = 1'b1;
                v1 = {~reg_a[3], 1'b1, ~base_reg[3], 5'd2};
                v2 = {1'b0, 4'hF, 1'b1, 2'd1};
                opn = 2'd1; ob0 = (op == OP_VPBCASTQ) ? 8'h59 : 8'h19;
                mem_en = 1'b1;
            end
            OP_VMOVDQU_LD, OP_VMOVDQU_ST, OP_VMOVUPD_LD, OP_VMOVUPD_ST:
            begin
                vex_en = 1'b1;
                v1 = {~reg_a[3], ~index_reg[3], ~base_reg[3], 5'd1};
                v2 = {1'b0, 4'hF, 1'b1,
                      (op == OP_VMOVDQU_LD || op == OP_VMOVDQU_ST) ? 2'd2 : 2'd1};
                opn = 2'd1;
                priority case (op)
                    OP_VMOVDQU_LD: ob0 = 8'h6F;
                    OP_VMOVDQU_ST: ob0 = 8'h7F;
                    OP_VMOVUPD_LD: ob0 = 8'h10;
                    default:       ob0 = 8'h11;
                endcase
                sib_en = 1'b1;
            end
            OP_VPADDQ_M, OP_VFMADD_M:
            begin
                vex_en = 1'b1;
                v1 = {~reg_a[3], ~index_reg[3], ~base_reg[3],
                      (op == OP_VPADDQ_M) ? 5'd1 : 5'd2};
                v2 = {(op == OP_VFMADD_M), ~reg_b, 1'b1, 2'd1};
                opn = 2'd1; ob0 = (op == OP_VPADDQ_M) ? 8'hD4 : 8'hB8;
                sib_en = 1'b1;
            end
            OP_VPMULUDQ, OP_VPADDQ_RR, OP_VMULPD, OP_VADDPD, OP_VFMADD_RR,
            OP_VXORPD:
            begin
                vex_en = 1'b1;
                v1 = {~reg_a[3], 1'b1, ~reg_c[3],
                      (op == OP_VFMADD_RR) ? 5'd2 : 5'd1};
                v2 = {(op == OP_VFMADD_RR), ~reg_b, 1'b1, 2'd1};
                opn = 2'd1;
                priority case (op)
                    OP_VPMULUDQ:  ob0 = 8'hF4;
                    OP_VPADDQ_RR: ob0 = 8'hD4;
                    OP_VMULPD:    ob0 = 8'h59;
                    OP_VADDPD:    ob0 = 8'h58;
                    OP_VFMADD_RR: ob0 = 8'hB8;
                    default:      ob0 = 8'h57;
                endcase
                modrm_en = 1'b1; mr_val = {2'b11, reg_a[2:0], reg_c[2:0]};
            end
            default:
            begin
                opn = 2'd0;
            end
        endcase
    end

    // assemble the byte run in order
    always_comb
    begin
        bb = '0;
        n  = '0;
        if (rex_en)
        begin
            bb[n] = rex_val; n = n + 1'b1;
        end
        if (vex_en)
        begin
            bb[n] = 8'hC4; n = n + 1'b1;
            bb[n] = v1;    n = n + 1'b1;
            bb[n] = v2;    n = n + 1'b1;
        end
        if (opn != 2'd0)
        begin
            bb[n] = ob0; n = n + 1'b1;
        end
        if (opn >= 2'd2)
        begin
            bb[n] = ob1; n = n + 1'b1;
        end
        if (opn == 2'd3)
        begin
            bb[n] = ob2; n = n + 1'b1;
        end
        if (modrm_en)
        begin
            bb[n] = mr_val; n = n + 1'b1;
        end
        if (mem_en || sib_en)
        begin
            bb[n] = {mode, mem_reg, sib_en ? 3'd4 : base_reg[2:0]};
            n = n + 1'b1;
            if (sib_en)
            begin
                bb[n] = {scale_code, index_reg[2:0], base_reg[2:0]};
                n = n + 1'b1;
            end
            else if (base_reg[2:0] == 3'd4)
            begin
                bb[n] = 8'h24; n = n + 1'b1;
            end
            if (mode != 2'd0)
            begin
                bb[n] = displacement[7:0]; n = n + 1'b1;
            end
            if (mode == 2'd2)
            begin
                bb[n] = displacement[15:8];  n = n + 1'b1;
                bb[n] = displacement[23:16]; n = n + 1'b1;
                bb[n] = displacement[31:24]; n = n + 1'b1;
            end
        end
        if (rel_en)
        begin
            bb[n] = rel[7:0];   n = n + 1'b1;
            bb[n] = rel[15:8];  n = n + 1'b1;
            bb[n] = rel[23:16]; n = n + 1'b1;
            bb[n] = rel[31:24]; n = n + 1'b1;
        end
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < imm_n)
            begin
                bb[n] = immediate[8*i +: 8]; n = n + 1'b1;
            end
        end
    end

    assign q_word.bytes = bb;
    assign q_word.count = n;
    assign q_push = push && !q_full && (n != '0);

    // advance the running offset on every accepted word
    always_comb
    begin
        offset_next = offset_reg;
        if (push && !q_full)
            offset_next = offset_reg + OFFSET_BITS'(n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else
            offset_reg <= offset_next;
    end

endmodule
`default_nettype wire

// File: rtl/core/xie_queue.sv
`default_nettype none
module xie_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr,
    input  wire xie_pkg::word_t wr_word,
    output logic            q_full,
    input  wire logic       rd,
    output logic            q_valid,
    output xie_pkg::word_t  rd_word
);
    import xie_pkg::*;

    word_t slot_reg [QUEUE_DEPTH];
    logic  wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == 2'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign rd_word = slot_reg[rp_reg];

    // advance pointers and fill count
    always_comb
    begin
        wp_next  = wp_reg + (wr ? 1'b1 : 1'b0);
        rp_next  = rp_reg + (rd ? 1'b1 : 1'b0);
        cnt_next = cnt_reg + (wr ? 2'd1 : 2'd0) - (rd ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // hold written words
    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wp_reg] <= wr_word;
    end

endmodule
`default_nettype wire

// File: rtl/core/xie_back.sv
`default_nettype none
module xie_back (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire xie_pkg::word_t q_word,
    output logic            q_rd,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      out_byte,
    output logic            last
);
    import xie_pkg::*;

    word_t cur_reg;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic busy_reg, busy_next;
    logic take;

    assign empty    = !busy_reg;
    assign out_byte = cur_reg.bytes[idx_reg];
    assign last     = (idx_reg == cur_reg.count - 1'b1);

    // load the next word once the current one is drained
    assign take = q_valid && (!busy_reg || (pop && last));
    assign q_rd = take;

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (take)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg && pop)
        begin
            if (last)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= q_word;
    end

endmodule
`default_nettype wire
